// ----- rtl/core/stx_pkg.sv -----
// stx_pkg: types, character codes and classifier functions for the
// S-expression token scanner. No dependencies.

package stx_pkg;

  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_NUL    = 8'h00;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_ATOM = 2'd1,
    MODE_STR  = 2'd2
  } mode_t;

  typedef enum logic [2:0] {
    CLS_START = 3'd0,
    CLS_SIGN  = 3'd1,
    CLS_DIG   = 3'd2,
    CLS_DBL   = 3'd3,
    CLS_LDOT  = 3'd4,
    CLS_REJ   = 3'd5
  } cls_t;

  typedef enum logic [3:0] {
    K_NONE   = 4'd0,
    K_LPAREN = 4'd1,
    K_RPAREN = 4'd2,
    K_DOT    = 4'd3,
    K_STRING = 4'd4,
    K_INT    = 4'd5,
    K_DOUBLE = 4'd6,
    K_SYMBOL = 4'd7,
    K_EOF    = 4'd8,
    K_LEXERR = 4'd9
  } kind_t;

  typedef struct packed {
    kind_t      token_kind;
    logic [7:0] text_byte;
    logic       byte_valid;
    logic       token_end;
  } result_t;

  // up to two results produced by one input item
  typedef struct packed {
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

  function automatic result_t mk_res(kind_t k, logic [7:0] b, logic bv, logic te);
    result_t r;
    r.token_kind = k;
    r.text_byte  = b;
    r.byte_valid = bv;
    r.token_end  = te;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  function automatic logic is_delim(logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_NL) || (c == CH_TAB) || (c == CH_LPAREN) ||
           (c == CH_RPAREN) || (c == CH_QUOTE) || (c == CH_SEMI);
  endfunction

  function automatic cls_t class_next(cls_t s, logic [7:0] c);
    cls_t n;
    n = CLS_REJ;
    case (s)
      CLS_START: begin
        if ((c == CH_PLUS) || (c == CH_MINUS)) n = CLS_SIGN;
        else if (is_digit(c))                  n = CLS_DIG;
        else if (c == CH_DOT)                  n = CLS_LDOT;
      end
      CLS_SIGN: begin
        if (is_digit(c))      n = CLS_DIG;
        else if (c == CH_DOT) n = CLS_LDOT;
      end
      CLS_DIG: begin
        if (is_digit(c))      n = CLS_DIG;
        else if (c == CH_DOT) n = CLS_DBL;
      end
      CLS_DBL, CLS_LDOT: begin
        if (is_digit(c)) n = CLS_DBL;
      end
      default: n = CLS_REJ;
    endcase
    return n;
  endfunction

  function automatic kind_t atom_kind(cls_t s);
    kind_t k;
    case (s)
      CLS_DIG: k = K_INT;
      CLS_DBL: k = K_DOUBLE;
      default: k = K_SYMBOL;
    endcase
    return k;
  endfunction

endpackage

// ----- rtl/core/stx_step.sv -----
// stx_step: scanner automaton, one character step.
// Next mode/classifier and up to two results. Depends on stx_pkg.

module stx_step import stx_pkg::*; (
  input  mode_t      mode,
  input  cls_t       cls,
  input  logic [7:0] char_in,
  input  logic       end_of_input,
  output mode_t      mode_nxt,
  output cls_t       cls_nxt,
  output push_t      push
);

  logic    idle_v;
  result_t idle_r;
  mode_t   idle_mode;
  cls_t    idle_cls;

  // handling of a character seen between tokens
  always_comb begin
    idle_v    = 1'b1;
    idle_r    = mk_res(K_NONE, char_in, 1'b1, 1'b0);
    idle_mode = MODE_IDLE;
    idle_cls  = CLS_START;
    case (char_in)
      CH_NUL, CH_SPACE, CH_NL, CH_TAB: idle_v = 1'b0;
      CH_LPAREN: idle_r = mk_res(K_LPAREN, char_in, 1'b1, 1'b1);
      CH_RPAREN: idle_r = mk_res(K_RPAREN, char_in, 1'b1, 1'b1);
      CH_DOT:    idle_r = mk_res(K_DOT, char_in, 1'b1, 1'b1);
      CH_QUOTE: begin
        idle_v    = 1'b0;
        idle_mode = MODE_STR;
      end
      default: begin
        idle_mode = MODE_ATOM;
        idle_cls  = class_next(CLS_START, char_in);
      end
    endcase
  end

  // next state
  always_comb begin
    mode_nxt = mode;
    cls_nxt  = cls;
    if (end_of_input) begin
      mode_nxt = MODE_IDLE;
      cls_nxt  = CLS_START;
    end else begin
      unique case (mode)
        MODE_STR: begin
          if (char_in == CH_QUOTE) mode_nxt = MODE_IDLE;
        end
        MODE_ATOM: begin
          if (!is_delim(char_in)) begin
            cls_nxt = class_next(cls, char_in);
          end else begin
            mode_nxt = idle_mode;
            cls_nxt  = idle_cls;
          end
        end
        default: begin
          mode_nxt = idle_mode;
          cls_nxt  = (idle_mode == MODE_ATOM) ? idle_cls : cls;
        end
      endcase
    end
  end

  // results
  always_comb begin
    push.n  = 2'd0;
    push.r0 = mk_res(K_NONE, 8'h00, 1'b0, 1'b0);
    push.r1 = mk_res(K_NONE, 8'h00, 1'b0, 1'b0);
    if (end_of_input) begin
      unique case (mode)
        MODE_STR: begin
          push.n  = 2'd1;
          push.r0 = mk_res(K_LEXERR, 8'h00, 1'b0, 1'b1);
        end
        MODE_ATOM: begin
          push.n  = 2'd2;
          push.r0 = mk_res(atom_kind(cls), 8'h00, 1'b0, 1'b1);
          push.r1 = mk_res(K_EOF, 8'h00, 1'b0, 1'b1);
        end
        default: begin
          push.n  = 2'd1;
          push.r0 = mk_res(K_EOF, 8'h00, 1'b0, 1'b1);
        end
      endcase
    end else begin
      unique case (mode)
        MODE_STR: begin
          push.n  = 2'd1;
          if (char_in == CH_QUOTE) push.r0 = mk_res(K_STRING, 8'h00, 1'b0, 1'b1);
          else                     push.r0 = mk_res(K_NONE, char_in, 1'b1, 1'b0);
        end
        MODE_ATOM: begin
          if (!is_delim(char_in)) begin
            push.n  = 2'd1;
            push.r0 = mk_res(K_NONE, char_in, 1'b1, 1'b0);
          end else begin
            // atom closes, the delimiter may give a second item
            push.n  = idle_v ? 2'd2 : 2'd1;
            push.r0 = mk_res(atom_kind(cls), 8'h00, 1'b0, 1'b1);
            push.r1 = idle_r;
          end
        end
        default: begin
          push.n  = idle_v ? 2'd1 : 2'd0;
          push.r0 = idle_r;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/stx_fifo.sv -----
// stx_fifo: small result queue, up to two writes and one read per cycle.
// Depends on stx_pkg.

module stx_fifo import stx_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  push_t   push,
  output logic    room2,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_res
);

  result_t            mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               pop;
  logic [PTR_W-1:0]   wr_ptr_p1;

  assign out_valid = (count_r != '0);
  assign out_res   = mem_r[rd_ptr_r];
  assign pop       = out_valid && out_ready;
  assign room2     = (count_r <= CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1 = wr_ptr_r + PTR_W'(1);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r + PTR_W'(push.n);
    rd_ptr_nxt = rd_ptr_r + PTR_W'(pop);
    count_nxt  = count_r + CNT_W'(push.n) - CNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r]  <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.r1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (4'(count_r) + 4'(push.n) - 4'(pop) <= 4'(FIFO_DEPTH)))
    else $error("result queue overflow");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == '0 && push.n != 2'd0) |=> out_valid)
    else $error("pushed item not visible");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r != '0 && count_r != CNT_W'(FIFO_DEPTH)) |-> (wr_ptr_r != rd_ptr_r))
    else $error("pointers disagree with count");

endmodule

// ----- rtl/core/sexpr_token_scanner.sv -----
// sexpr_token_scanner: streaming S-expression tokenizer, top level.
// Uses stx_pkg, stx_step and stx_fifo.
//
// Input channel in_*: one character per item in in_tdata[7:0]; in_tlast
// marks end of input (no character carried). Result channel out_*: text
// bytes of atoms and strings stream out as they arrive, and an item with
// out_tlast set closes each token and carries its kind in out_tuser.
// Each input item gives zero, one or two result items.
// Path: an accepted item is held in the input register, its results are
// written into a four-entry result queue once two queue slots are free,
// and out_tvalid rises once the queue holds an item.
// Throughput: one input item per cycle while each item gives at most one
// result and the receiver keeps up; an item that gives two results (atom
// closed by a paren or by a semicolon that starts a new atom, or end of
// input with an open atom) puts both into the queue for the single port.
// The step waits while fewer than two queue slots are free, so a stalled
// receiver drops in_tready while the input item waits; nothing is lost.
// Reset: synchronous, active low; scanner returns to between tokens, queue
// and input register empty.

module sexpr_token_scanner import stx_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,   // end_of_input
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] text_byte, [8] byte_valid, [15:9] zero
  output logic [3:0]  out_tuser,  // [3:0] token_kind
  output logic        out_tlast   // token_end
);

  logic       in_v_r, in_v_nxt;
  logic [7:0] char_r;
  logic       eoi_r;
  mode_t      mode_r, mode_nxt;
  cls_t       cls_r, cls_nxt;
  push_t      step_push, push;
  logic       room2;
  logic       step_go;
  result_t    out_res;

  assign step_go   = in_v_r && room2;
  assign in_tready = !in_v_r || room2;

  always_comb begin
    in_v_nxt = in_v_r;
    if (in_tvalid && in_tready) in_v_nxt = 1'b1;
    else if (step_go)           in_v_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      char_r <= in_tdata;
      eoi_r  <= in_tlast;
    end
  end

  stx_step u_step (
    .mode         (mode_r),
    .cls          (cls_r),
    .char_in      (char_r),
    .end_of_input (eoi_r),
    .mode_nxt     (mode_nxt),
    .cls_nxt      (cls_nxt),
    .push         (step_push)
  );

  always_comb begin
    push = step_push;
    if (!step_go) push.n = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
      mode_r <= MODE_IDLE;
      cls_r  <= CLS_START;
    end else begin
      in_v_r <= in_v_nxt;
      if (step_go) begin
        mode_r <= mode_nxt;
        cls_r  <= cls_nxt;
      end
    end
  end

  stx_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  assign out_tdata = {7'd0, out_res.byte_valid, out_res.text_byte};
  assign out_tuser = out_res.token_kind;
  assign out_tlast = out_res.token_end;

endmodule

// ----- tb/sv/testbench.sv -----
`timescale 1ns / 100ps
// testbench: self-checking bench for sexpr_token_scanner. A directed run and
// random token streams go into the input channel, and a token predictor checks
// every result item. Depends on stx_pkg and the sexpr_token_scanner RTL.

module testbench;
  import stx_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       eoi;
  } char_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic [3:0]  out_tuser;
  logic        out_tlast;

  char_item_t  char_stream[$];   // items not yet accepted, head is on the bus
  result_t     scan_results[$];  // predicted token items, oldest first
  mode_t       scan_state = MODE_IDLE;
  cls_t        num_state = CLS_START;
  int unsigned mismatches = 0;
  int unsigned cyc = 0;
  int unsigned hold_left = 0;
  bit          in_fire = 1'b0;

  sexpr_token_scanner dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
  end

  initial begin
    #(1_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- predictor

  function automatic bit breaks_atom(logic [7:0] c);
    case (c)
      CH_SPACE, CH_NL, CH_TAB, CH_LPAREN, CH_RPAREN, CH_QUOTE, CH_SEMI: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic cls_t num_advance(cls_t s, logic [7:0] c);
    bit dig, sgn, pt;
    dig = (c >= CH_ZERO) && (c <= CH_NINE);
    sgn = (c == CH_PLUS) || (c == CH_MINUS);
    pt  = (c == CH_DOT);
    case (s)
      CLS_START:         return sgn ? CLS_SIGN : dig ? CLS_DIG : pt ? CLS_LDOT : CLS_REJ;
      CLS_SIGN:          return dig ? CLS_DIG : pt ? CLS_LDOT : CLS_REJ;
      CLS_DIG:           return dig ? CLS_DIG : pt ? CLS_DBL : CLS_REJ;
      CLS_DBL, CLS_LDOT: return dig ? CLS_DBL : CLS_REJ;
      default:           return CLS_REJ;
    endcase
  endfunction

  function automatic kind_t atom_token(cls_t s);
    if (s == CLS_DIG) return K_INT;
    if (s == CLS_DBL) return K_DOUBLE;
    return K_SYMBOL;
  endfunction

  task automatic push_token(kind_t k, logic [7:0] b, logic bv, logic te);
    result_t r;
    r.token_kind = k;
    r.text_byte  = b;
    r.byte_valid = bv;
    r.token_end  = te;
    scan_results.push_back(r);
  endtask

  task automatic scan_char(logic [7:0] c, logic eoi);
    if (eoi) begin
      if (scan_state == MODE_STR) begin
        push_token(K_LEXERR, 8'h00, 1'b0, 1'b1);
      end else begin
        if (scan_state == MODE_ATOM) push_token(atom_token(num_state), 8'h00, 1'b0, 1'b1);
        push_token(K_EOF, 8'h00, 1'b0, 1'b1);
      end
      scan_state = MODE_IDLE;
      num_state  = CLS_START;
    end else if (scan_state == MODE_STR) begin
      if (c == CH_QUOTE) begin
        push_token(K_STRING, 8'h00, 1'b0, 1'b1);
        scan_state = MODE_IDLE;
      end else begin
        push_token(K_NONE, c, 1'b1, 1'b0);
      end
    end else if (scan_state == MODE_ATOM && !breaks_atom(c)) begin
      push_token(K_NONE, c, 1'b1, 1'b0);
      num_state = num_advance(num_state, c);
    end else begin
      // a delimiter closes the atom, then counts as a fresh character
      if (scan_state == MODE_ATOM) begin
        push_token(atom_token(num_state), 8'h00, 1'b0, 1'b1);
        scan_state = MODE_IDLE;
        num_state  = CLS_START;
      end
      case (c)
        CH_NUL, CH_SPACE, CH_NL, CH_TAB: ;
        CH_LPAREN: push_token(K_LPAREN, c, 1'b1, 1'b1);
        CH_RPAREN: push_token(K_RPAREN, c, 1'b1, 1'b1);
        CH_DOT:    push_token(K_DOT, c, 1'b1, 1'b1);
        CH_QUOTE:  scan_state = MODE_STR;
        default: begin
          push_token(K_NONE, c, 1'b1, 1'b0);
          scan_state = MODE_ATOM;
          num_state  = num_advance(CLS_START, c);
        end
      endcase
    end
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic add_byte(logic [7:0] c);
    char_item_t it;
    it.ch  = c;
    it.eoi = 1'b0;
    char_stream.push_back(it);
  endtask

  task automatic add_end();
    char_item_t it;
    it.ch  = 8'($urandom_range(255));   // ignored by the block
    it.eoi = 1'b1;
    char_stream.push_back(it);
  endtask

  task automatic add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endtask

  task automatic add_digits(int n);
    for (int i = 0; i < n; i++) add_byte(CH_ZERO + 8'($urandom_range(9)));
  endtask

  function automatic logic [7:0] atom_char();
    logic [7:0] c;
    do begin
      if ($urandom_range(3) == 0) c = 8'($urandom_range(255));
      else                        c = 8'($urandom_range(126, 33));
    end while (breaks_atom(c));
    return c;
  endfunction

  task automatic add_string(bit closed);
    int n;
    logic [7:0] c;
    n = $urandom_range(8);
    add_byte(CH_QUOTE);
    for (int i = 0; i < n; i++) begin
      do c = 8'($urandom_range(255)); while (c == CH_QUOTE);
      add_byte(c);
    end
    if (closed) add_byte(CH_QUOTE);
    else        add_end();
  endtask

  task automatic add_random_stream();
    string mix;
    int n;
    mix = "+-.0123456789";
    while (char_stream.size() < 1700) begin
      case ($urandom_range(19))
        0, 1, 2, 3: begin   // well-formed int or double
          if ($urandom_range(1)) add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
          add_digits($urandom_range(4, 1));
          if ($urandom_range(1)) begin
            add_byte(CH_DOT);
            add_digits($urandom_range(3));
          end
        end
        4: begin            // sign and leading dot, then up to three digits (a double if any)
          add_byte($urandom_range(1) ? CH_PLUS : CH_MINUS);
          add_byte(CH_DOT);
          add_digits($urandom_range(3));
        end
        5, 6, 7: begin
          n = $urandom_range(6, 1);
          for (int i = 0; i < n; i++) add_byte(atom_char());
        end
        8, 9: add_string(1'b1);
        10, 11: add_byte(CH_LPAREN);
        12, 13: add_byte(CH_RPAREN);
        14: add_byte(CH_DOT);
        15: begin
          n = $urandom_range(3, 1);
          for (int i = 0; i < n; i++) add_byte(8'($urandom_range(255)));
        end
        16: begin
          add_byte(CH_SEMI);
          if ($urandom_range(1)) add_byte(atom_char());
        end
        17: if ($urandom_range(2) == 0) add_string(1'b0); else add_end();
        18: begin           // random mix of sign, dot and digit characters for the classifier
          n = $urandom_range(5, 1);
          for (int i = 0; i < n; i++) add_byte(mix[$urandom_range(mix.len() - 1)]);
        end
        default: begin
          n = $urandom_range(3, 1);
          for (int i = 0; i < n; i++)
            case ($urandom_range(3))
              0: add_byte(CH_SPACE);
              1: add_byte(CH_NL);
              2: add_byte(CH_TAB);
              default: add_byte(CH_NUL);
            endcase
        end
      endcase
      case ($urandom_range(3))
        0: add_byte(CH_SPACE);
        1: add_byte($urandom_range(1) ? CH_NL : CH_TAB);
        default: ;
      endcase
    end
    add_end();
  endtask

  initial begin
    // directed: parens, int closed by rparen, sign-dot double, trailing-dot
    // double, skipped NUL, semicolon atoms, string with 0xFF, lone dot, NUL in
    // atom then end of input, open string at end, bare end of input
    add_text("(-12)");
    add_text("+.5\t");
    add_text("3.\n");
    add_byte(CH_NUL);
    add_text(";x;");
    add_byte(CH_QUOTE);
    add_byte(8'hFF);
    add_byte(CH_QUOTE);
    add_byte(CH_DOT);
    add_byte("a");
    add_byte(CH_NUL);
    add_end();
    add_text("\"q");
    add_end();
    add_end();
    add_random_stream();

    while (char_stream.size() != 0 || scan_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("Simulation PASSED");
    else                 $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------- driver

  function automatic bit gap_now();
    // random gaps, none in the tail of each window of the cycle count
    return ($urandom_range(99) < 16) && ((cyc % 2000) < 1400);
  endfunction

  always @(negedge clk) begin : drive_in
    bit offer;
    if (in_fire) void'(char_stream.pop_front());
    if (!rst_n)                      offer = 1'b0;
    else if (in_tvalid && !in_fire)  offer = 1'b1;
    else                             offer = (char_stream.size() != 0) && !gap_now();
    in_tvalid <= offer;
    if (offer) begin
      in_tdata <= char_stream[0].ch;
      in_tlast <= char_stream[0].eoi;
    end
  end

  // receiver, with two long hold-offs so the result queue fills up
  always @(negedge clk) begin
    if (cyc == 800 || cyc == 2300) hold_left = 300;
    if (hold_left != 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else begin
      out_tready <= rst_n && !gap_now();
    end
  end

  // ---------------------------------------------------------------- monitor

  task automatic note_mismatch(string what, result_t want, result_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t %s: expected kind=%0d byte=%02h bv=%b end=%b, got kind=%0d byte=%02h bv=%b end=%b",
               $realtime, what, want.token_kind, want.text_byte, want.byte_valid,
               want.token_end, got.token_kind, got.text_byte, got.byte_valid, got.token_end);
  endtask

  always @(posedge clk) begin : watch
    result_t got, want;
    cyc++;
    in_fire = rst_n && in_tvalid && in_tready;
    if (in_fire) scan_char(in_tdata, in_tlast);
    if (rst_n && out_tvalid && out_tready) begin
      got.token_kind = kind_t'(out_tuser);
      got.text_byte  = out_tdata[7:0];
      got.byte_valid = out_tdata[8];
      got.token_end  = out_tlast;
      if (scan_results.size() == 0) begin
        note_mismatch("unexpected item", '0, got);
      end else begin
        want = scan_results.pop_front();
        if (got.token_kind != want.token_kind || got.text_byte != want.text_byte ||
            got.byte_valid != want.byte_valid || got.token_end != want.token_end)
          note_mismatch("item mismatch", want, got);
      end
    end
  end

endmodule
